// ----- sv/mass_spring_cloth_step_top_macros.svh -----
// assertion macros for the cloth step block
`ifndef MASS_SPRING_CLOTH_STEP_TOP_MACROS_SVH
`define MASS_SPRING_CLOTH_STEP_TOP_MACROS_SVH

// property that must hold outside reset
`define MSC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define MSC_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- sv/msc_pkg.sv -----
// shared types, constants and link table for the cloth step block
package msc_pkg;

  localparam int DEF_GRID_WIDTH  = 16;
  localparam int DEF_GRID_HEIGHT = 16;

  localparam int LINK_COUNT = 12;
  localparam int LINK_W     = 4;

  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [30:0]        SPRING_RESET  = 31'd6553600;
  localparam logic [15:0]        STEP_RESET    = 16'd131;
  localparam logic signed [31:0] GRAVITY_RESET = 32'sd642253;

  localparam logic [31:0] REST_STRUCT = 32'd131072;
  localparam logic [31:0] REST_SHEAR  = 32'd185364;
  localparam logic [31:0] REST_BEND   = 32'd262144;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SPRING  = 2'd0,
    REG_STEP    = 2'd1,
    REG_GRAVITY = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] vertex_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               step_done;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic vtx_first;
    logic vtx_next;
    logic link_first;
    logic link_next;
    logic clear_write;
    logic rd_pos;
    logic rd_self;
    logic rd_other;
    logic cap_self;
    logic cap_diff;
    logic sq_go;
    logic root_go;
    logic force_go;
    logic fsat_go;
    logic prod_go;
    logic div_go;
    logic acc_init;
    logic acc_add;
    logic acc_write;
    logic b_rd;
    logic b_mul1;
    logic b_vel;
    logic b_mul2;
    logic b_write;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_vtx;
    logic last_link;
    logic link_ok;
    logic root_done;
    logic len_zero;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic signed [2:0] link_dc(input logic [LINK_W-1:0] k);
    logic signed [2:0] d;
    unique case (k)
      0, 4, 6: d = 3'sd1;
      1, 5, 7: d = -3'sd1;
      8:       d = 3'sd2;
      9:       d = -3'sd2;
      default: d = 3'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [2:0] link_dr(input logic [LINK_W-1:0] k);
    logic signed [2:0] d;
    unique case (k)
      2, 4, 5: d = 3'sd1;
      3, 6, 7: d = -3'sd1;
      10:      d = 3'sd2;
      11:      d = -3'sd2;
      default: d = 3'sd0;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] link_rest(input logic [LINK_W-1:0] k);
    logic [31:0] r;
    unique case (k)
      0, 1, 2, 3: r = REST_STRUCT;
      4, 5, 6, 7: r = REST_SHEAR;
      default:    r = REST_BEND;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/msc_ram.sv -----
// generic single-port-write ram with registered read
module msc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/msc_sqrt.sv -----
// iterative 64-bit integer square root, one result bit per cycle
module msc_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [63:0] n;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic        take;

  assign trial = res + bitv;
  assign take  = n >= trial;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv == 64'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n    <= radicand;
      res  <= 64'd0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      n    <= take ? n - trial : n;
      res  <= take ? (res >> 1) + bitv : res >> 1;
      bitv <= bitv >> 2;
    end
  end

endmodule

// ----- sv/msc_div.sv -----
// restoring divider, signed 64-bit by unsigned 32-bit, quotient truncated toward zero
module msc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic [31:0]        divisor,
  output logic               done,
  output logic signed [32:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic        neg;
  logic [31:0] dvs;
  logic [31:0] rem;
  logic [63:0] quo;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh   = {rem, quo[63]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = neg ? -$signed(quo[32:0]) : $signed(quo[32:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[63];
      quo <= dividend[63] ? 64'(-dividend) : 64'(dividend);
      rem <= 32'd0;
      cnt <= 6'd0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
      quo <= {quo[62:0], ge};
      cnt <= cnt + 6'd1;
    end
  end

endmodule

// ----- sv/msc_ctrl.sv -----
// sequencer for clearing, reads and the two phases of a time step
module msc_ctrl import msc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_opcode,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [22:0] {
    S_CLEAR   = 23'd1 << 0,
    S_IDLE    = 23'd1 << 1,
    S_RD      = 23'd1 << 2,
    S_OUT     = 23'd1 << 3,
    S_A_SELF  = 23'd1 << 4,
    S_A_SELFL = 23'd1 << 5,
    S_A_LINK  = 23'd1 << 6,
    S_A_DIFF  = 23'd1 << 7,
    S_A_SQ    = 23'd1 << 8,
    S_A_ROOT  = 23'd1 << 9,
    S_A_ROOTW = 23'd1 << 10,
    S_A_FORCE = 23'd1 << 11,
    S_A_FSAT  = 23'd1 << 12,
    S_A_PROD  = 23'd1 << 13,
    S_A_DIVGO = 23'd1 << 14,
    S_A_DIVW  = 23'd1 << 15,
    S_A_ACC   = 23'd1 << 16,
    S_A_WRITE = 23'd1 << 17,
    S_B_RD    = 23'd1 << 18,
    S_B_MUL1  = 23'd1 << 19,
    S_B_VEL   = 23'd1 << 20,
    S_B_MUL2  = 23'd1 << 21,
    S_B_POS   = 23'd1 << 22
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_write = 1'b1;
        cmd.vtx_next    = 1'b1;
        if (status.last_vtx) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (in_opcode == OP_READ) begin
            state_next = S_RD;
          end else begin
            cmd.vtx_first = 1'b1;
            state_next    = S_A_SELF;
          end
        end
      end
      S_RD: begin
        cmd.rd_pos = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_A_SELF: begin
        cmd.rd_self = 1'b1;
        state_next  = S_A_SELFL;
      end
      S_A_SELFL: begin
        cmd.cap_self   = 1'b1;
        cmd.link_first = 1'b1;
        cmd.acc_init   = 1'b1;
        state_next     = S_A_LINK;
      end
      S_A_LINK: begin
        if (status.link_ok) begin
          cmd.rd_other = 1'b1;
          state_next   = S_A_DIFF;
        end else if (status.last_link) begin
          state_next = S_A_WRITE;
        end else begin
          cmd.link_next = 1'b1;
        end
      end
      S_A_DIFF: begin
        cmd.cap_diff = 1'b1;
        state_next   = S_A_SQ;
      end
      S_A_SQ: begin
        cmd.sq_go  = 1'b1;
        state_next = S_A_ROOT;
      end
      S_A_ROOT: begin
        cmd.root_go = 1'b1;
        state_next  = S_A_ROOTW;
      end
      S_A_ROOTW: begin
        if (status.root_done) begin
          if (!status.len_zero) begin
            state_next = S_A_FORCE;
          end else if (status.last_link) begin
            state_next = S_A_WRITE;
          end else begin
            cmd.link_next = 1'b1;
            state_next    = S_A_LINK;
          end
        end
      end
      S_A_FORCE: begin
        cmd.force_go = 1'b1;
        state_next   = S_A_FSAT;
      end
      S_A_FSAT: begin
        cmd.fsat_go = 1'b1;
        state_next  = S_A_PROD;
      end
      S_A_PROD: begin
        cmd.prod_go = 1'b1;
        state_next  = S_A_DIVGO;
      end
      S_A_DIVGO: begin
        cmd.div_go = 1'b1;
        state_next = S_A_DIVW;
      end
      S_A_DIVW: begin
        if (status.div_done) state_next = S_A_ACC;
      end
      S_A_ACC: begin
        cmd.acc_add = 1'b1;
        if (status.last_link) begin
          state_next = S_A_WRITE;
        end else begin
          cmd.link_next = 1'b1;
          state_next    = S_A_LINK;
        end
      end
      S_A_WRITE: begin
        cmd.acc_write = 1'b1;
        cmd.vtx_next  = 1'b1;
        state_next    = status.last_vtx ? S_B_RD : S_A_SELF;
      end
      S_B_RD: begin
        cmd.b_rd   = 1'b1;
        state_next = S_B_MUL1;
      end
      S_B_MUL1: begin
        cmd.b_mul1 = 1'b1;
        state_next = S_B_VEL;
      end
      S_B_VEL: begin
        cmd.b_vel  = 1'b1;
        state_next = S_B_MUL2;
      end
      S_B_MUL2: begin
        cmd.b_mul2 = 1'b1;
        state_next = S_B_POS;
      end
      S_B_POS: begin
        cmd.b_write  = 1'b1;
        cmd.vtx_next = 1'b1;
        state_next   = status.last_vtx ? S_OUT : S_B_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- sv/msc_dp.sv -----
// datapath: vertex stores, spring arithmetic, integration and result register
module msc_dp import msc_pkg::*; #(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output out_item_t             out_item
);

  localparam int VC = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW = $clog2(VC);
  localparam int CW = $clog2(GRID_WIDTH);
  localparam int RW = $clog2(GRID_HEIGHT);
  localparam int IW = ((AW > 8) ? AW : 8) + 1;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [65:0] trunc16(input logic signed [65:0] v);
    logic signed [65:0] a;
    a = v[65] ? v + 66'sd65535 : v;
    return a >>> 16;
  endfunction

  // configuration
  logic [30:0]        spring_const;
  logic [15:0]        time_step;
  logic signed [31:0] gravity_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_const <= SPRING_RESET;
      time_step    <= STEP_RESET;
      gravity_y    <= GRAVITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPRING:  spring_const <= cfg_data[30:0];
        REG_STEP:    time_step    <= cfg_data[15:0];
        REG_GRAVITY: gravity_y    <= $signed(cfg_data[31:0]);
        default: ;
      endcase
    end
  end

  // item and counters
  in_item_t          item;
  logic [AW-1:0]     vtx;
  logic [RW-1:0]     row;
  logic [CW-1:0]     col;
  logic [LINK_W-1:0] link;

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx  <= '0;
      row  <= '0;
      col  <= '0;
      link <= '0;
    end else begin
      if (cmd.vtx_first || (cmd.vtx_next && status.last_vtx)) begin
        vtx <= '0;
        row <= '0;
        col <= '0;
      end else if (cmd.vtx_next) begin
        vtx <= vtx + 1'b1;
        if (col == CW'(GRID_WIDTH - 1)) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      if (cmd.link_first) link <= '0;
      else if (cmd.link_next) link <= link + 1'b1;
    end
  end

  // neighbour geometry
  logic signed [CW+1:0] col_n;
  logic signed [RW+1:0] row_n;
  logic [AW-1:0]        other;
  int                   off;

  always_comb begin
    col_n = $signed({2'b00, col}) + (CW+2)'(link_dc(link));
    row_n = $signed({2'b00, row}) + (RW+2)'(link_dr(link));
    off   = int'(link_dr(link)) * GRID_WIDTH + int'(link_dc(link));
    other = AW'(int'(vtx) + off);
  end

  assign status.link_ok = !col_n[CW+1] && (col_n[CW:0] < (CW+1)'(GRID_WIDTH)) &&
                          !row_n[RW+1] && (row_n[RW:0] < (RW+1)'(GRID_HEIGHT));
  assign status.last_vtx  = vtx == AW'(VC - 1);
  assign status.last_link = link == LINK_W'(LINK_COUNT - 1);

  // read address of a read item
  logic [IW-1:0] idx_ext;
  logic          in_range;
  assign idx_ext  = IW'(item.vertex_index);
  assign in_range = idx_ext < IW'(VC);

  // stores
  logic          pos_re;
  logic [AW-1:0] pos_raddr;
  logic          pos_we;
  logic          vel_we;
  logic [31:0]   pos_x_wd, pos_y_wd, vel_x_wd, vel_y_wd, acc_x_wd, acc_y_wd;
  logic [31:0]   pos_x_rd, pos_y_rd, vel_x_rd, vel_y_rd, acc_x_rd, acc_y_rd;
  logic [15:0]   init_x, init_y;

  assign pos_re = cmd.rd_pos || cmd.rd_self || cmd.rd_other || cmd.b_rd;
  assign pos_we = cmd.clear_write || cmd.b_write;
  assign vel_we = cmd.clear_write || cmd.b_write;

  always_comb begin
    priority if (cmd.rd_pos) pos_raddr = idx_ext[AW-1:0];
    else if (cmd.rd_other)   pos_raddr = other;
    else                     pos_raddr = vtx;
  end

  assign init_x = 16'(10 + 2 * int'(col));
  assign init_y = 16'(10 + 2 * int'(row));

  msc_ram #(.WIDTH(32), .DEPTH(VC)) u_pos_x (
    .clk(clk), .we(pos_we), .waddr(vtx), .wdata(pos_x_wd),
    .re(pos_re), .raddr(pos_raddr), .rdata(pos_x_rd));
  msc_ram #(.WIDTH(32), .DEPTH(VC)) u_pos_y (
    .clk(clk), .we(pos_we), .waddr(vtx), .wdata(pos_y_wd),
    .re(pos_re), .raddr(pos_raddr), .rdata(pos_y_rd));
  msc_ram #(.WIDTH(32), .DEPTH(VC)) u_vel_x (
    .clk(clk), .we(vel_we), .waddr(vtx), .wdata(vel_x_wd),
    .re(cmd.b_rd), .raddr(vtx), .rdata(vel_x_rd));
  msc_ram #(.WIDTH(32), .DEPTH(VC)) u_vel_y (
    .clk(clk), .we(vel_we), .waddr(vtx), .wdata(vel_y_wd),
    .re(cmd.b_rd), .raddr(vtx), .rdata(vel_y_rd));
  msc_ram #(.WIDTH(32), .DEPTH(VC)) u_acc_x (
    .clk(clk), .we(cmd.acc_write), .waddr(vtx), .wdata(acc_x_wd),
    .re(cmd.b_rd), .raddr(vtx), .rdata(acc_x_rd));
  msc_ram #(.WIDTH(32), .DEPTH(VC)) u_acc_y (
    .clk(clk), .we(cmd.acc_write), .waddr(vtx), .wdata(acc_y_wd),
    .re(cmd.b_rd), .raddr(vtx), .rdata(acc_y_rd));

  // spring term
  logic signed [31:0] self_x, self_y;
  logic signed [31:0] dx, dy;
  logic [63:0]        sq_x, sq_y;
  logic [31:0]        len;
  logic signed [32:0] stretch;
  logic signed [64:0] fprod;
  logic signed [31:0] f;
  logic signed [63:0] px, py;
  logic signed [32:0] qx, qy;
  logic               div_y_done;
  logic signed [39:0] ax, ay;
  logic               corner;

  assign stretch = $signed({1'b0, len}) - $signed({1'b0, link_rest(link)});

  always_ff @(posedge clk) begin
    if (cmd.cap_self) begin
      self_x <= $signed(pos_x_rd);
      self_y <= $signed(pos_y_rd);
    end
    if (cmd.cap_diff) begin
      dx <= sat32(66'(self_x) - 66'($signed(pos_x_rd)));
      dy <= sat32(66'(self_y) - 66'($signed(pos_y_rd)));
    end
    if (cmd.sq_go) begin
      sq_x <= 64'(64'(dx) * 64'(dx));
      sq_y <= 64'(64'(dy) * 64'(dy));
    end
    if (cmd.force_go) fprod <= 65'($signed({1'b0, spring_const})) * 65'(stretch);
    if (cmd.fsat_go) f <= sat32(-trunc16(66'(fprod)));
    if (cmd.prod_go) begin
      px <= 64'(f) * 64'(dx);
      py <= 64'(f) * 64'(dy);
    end
    if (cmd.acc_init) begin
      ax <= '0;
      ay <= 40'(gravity_y);
    end else if (cmd.acc_add) begin
      ax <= ax + 40'(qx);
      ay <= ay + 40'(qy);
    end
  end

  msc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.root_go), .radicand(sq_x + sq_y),
    .done(status.root_done), .root(len));

  msc_div u_div_x (
    .clk(clk), .rst(rst), .start(cmd.div_go), .dividend(px), .divisor(len),
    .done(status.div_done), .quotient(qx));
  msc_div u_div_y (
    .clk(clk), .rst(rst), .start(cmd.div_go), .dividend(py), .divisor(len),
    .done(div_y_done), .quotient(qy));

  assign status.len_zero = len == 32'd0 && !div_y_done;

  // the two top corners stay pinned
  assign corner   = vtx == '0 || vtx == AW'(GRID_WIDTH - 1);
  assign acc_x_wd = corner ? 32'd0 : sat32(66'(ax));
  assign acc_y_wd = corner ? 32'd0 : sat32(66'(ay));

  // integration
  logic signed [16:0] dt;
  logic signed [48:0] mvx, mvy, mpx, mpy;
  logic signed [31:0] nvx, nvy;

  assign dt = $signed({1'b0, time_step});

  always_ff @(posedge clk) begin
    if (cmd.b_mul1) begin
      mvx <= 49'($signed(acc_x_rd)) * 49'(dt);
      mvy <= 49'($signed(acc_y_rd)) * 49'(dt);
    end
    if (cmd.b_vel) begin
      nvx <= sat32(66'($signed(vel_x_rd)) + trunc16(66'(mvx)));
      nvy <= sat32(66'($signed(vel_y_rd)) + trunc16(66'(mvy)));
    end
    if (cmd.b_mul2) begin
      mpx <= 49'(nvx) * 49'(dt);
      mpy <= 49'(nvy) * 49'(dt);
    end
  end

  assign pos_x_wd = cmd.clear_write ? {init_x, 16'd0}
                                    : sat32(66'($signed(pos_x_rd)) + trunc16(66'(mpx)));
  assign pos_y_wd = cmd.clear_write ? {init_y, 16'd0}
                                    : sat32(66'($signed(pos_y_rd)) + trunc16(66'(mpy)));
  assign vel_x_wd = cmd.clear_write ? 32'd0 : nvx;
  assign vel_y_wd = cmd.clear_write ? 32'd0 : nvy;

  // result register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (item.opcode == OP_READ && in_range) begin
        out_item.pos_x <= $signed(pos_x_rd);
        out_item.pos_y <= $signed(pos_y_rd);
      end else begin
        out_item.pos_x <= '0;
        out_item.pos_y <= '0;
      end
      out_item.step_done <= item.opcode == OP_TICK;
    end
  end

endmodule

// ----- sv/mass_spring_cloth_step_top.sv -----
// top level of the mass-spring cloth step block
// A tick advances the whole grid by one symplectic Euler step in two passes: first every
// vertex's spring acceleration is built from the old positions, one spring at a time, with
// a wait on the square root and on the divide for each in-grid neighbour and a neighbour
// outside the grid skipped; then velocity and position are updated vertex by vertex. A
// 16x16 grid has 2756 in-grid neighbour links, and most of a tick is spent waiting on the
// root and divide units. A read goes through a registered store read and then the result
// register. After reset the block writes the initial grid into the stores before it takes
// its first item.
// One item is in work at a time; a finished result waits in the output register.
`include "mass_spring_cloth_step_top_macros.svh"

module mass_spring_cloth_step_top import msc_pkg::*; #(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  msc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_opcode(in_item.opcode),
    .in_ready(in_ready), .status(status), .cmd(cmd));

  msc_dp #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_ready(out_ready), .out_valid(out_valid), .out_item(out_item));

  logic       in_xfer;
  logic [3:0] rd_srcs;
  logic       tick_pos;

  assign in_xfer  = in_valid && in_ready;
  assign rd_srcs  = {cmd.rd_pos, cmd.rd_self, cmd.rd_other, cmd.b_rd};
  assign tick_pos = out_item.step_done && (out_item.pos_x != '0 || out_item.pos_y != '0);

  `MSC_ASSERT(a_load_when_free, clk, rst, cmd.out_load |-> status.out_free, "result overwritten")
  `MSC_ASSERT(a_busy_after_transfer, clk, rst, in_xfer |=> !in_ready, "second item taken")
  `MSC_ASSERT(a_one_read_source, clk, rst, $onehot0(rd_srcs), "read address conflict")
  `MSC_NEVER(a_tick_result_zero, clk, rst, out_valid && tick_pos, "tick result has position")

endmodule
